// ===== hdl/strc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strc_pkg
// shared constants and controller/datapath interface types for the
// segment tree range cover block
// ----------------------------------------------------------------------------
package strc_pkg;

    localparam int          ADDR_BITS_DEF = 16;
    localparam int          UNIV_W        = 17;
    localparam int          RANGE_W       = 16;
    localparam int          IN_TDATA_W    = 2 * RANGE_W;
    localparam int          MAX_RESULTS   = 32;
    localparam logic [16:0] UNIV_RESET    = 17'd65536;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture and order the bounds
        logic setup;     // clamp and form leaf indices
        logic step;      // one tree level of the upward walk
        logic pop_rd;    // read top of right-side stack
        logic pop_emit;  // hand popped node to the held-node slot
        logic finish;    // send held node marked as last
    } strc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic l_le_r;
        logic step_ok;
        logic emit_ok;
        logic out_free;
        logic stack_empty;
    } strc_sts_t;

endpackage
`default_nettype wire

// ===== hdl/strc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module strc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 17
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/strc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strc_ctrl
// sequencer for one query: setup, upward walk, stack unwind, final node
// ----------------------------------------------------------------------------
module strc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire strc_pkg::strc_sts_t sts,
    output strc_pkg::strc_cmd_t      cmd
);

    import strc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SETUP    = 6'b000010,
        ST_CLIMB    = 6'b000100,
        ST_POP_RD   = 6'b001000,
        ST_POP_EMIT = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_CLIMB;
            end
            ST_CLIMB:
            begin
                if (!sts.l_le_r)
                begin
                    state_next = sts.stack_empty ? ST_FINISH : ST_POP_RD;
                end
                else if (sts.step_ok)
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_EMIT;
            end
            ST_POP_EMIT:
            begin
                if (sts.emit_ok)
                begin
                    cmd.pop_emit = 1'b1;
                    state_next   = sts.stack_empty ? ST_FINISH : ST_POP_RD;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/strc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strc_dp
// datapath: universe register, bound ordering and clamping, leaf walk,
// right-side stack, held node and output register
// ----------------------------------------------------------------------------
module strc_dp #(
    parameter int ADDR_BITS = strc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [strc_pkg::UNIV_W-1:0]    cfg_value,
    input  wire logic [strc_pkg::RANGE_W-1:0]   range_low,
    input  wire logic [strc_pkg::RANGE_W-1:0]   range_high,
    input  wire strc_pkg::strc_cmd_t            cmd,
    output strc_pkg::strc_sts_t                 sts,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ADDR_BITS:0]                  out_node,
    output logic                                out_last
);

    import strc_pkg::*;

    localparam int NW    = ADDR_BITS + 1;
    localparam int LW    = ADDR_BITS + 2;
    localparam int UW    = (NW > UNIV_W) ? NW : UNIV_W;
    localparam int CW    = (ADDR_BITS > RANGE_W) ? ADDR_BITS : RANGE_W;
    localparam int DEPTH = ADDR_BITS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SCW   = $clog2(DEPTH + 1);
    localparam int ECW   = $clog2(MAX_RESULTS + 1);

    // {leaf base, universe minus one} for a raw universe value
    function automatic logic [NW+ADDR_BITS-1:0] geom(input logic [UNIV_W-1:0] u);
        logic [UW-1:0]        ue;
        logic [UW-1:0]        cap;
        logic [ADDR_BITS-1:0] m;
        logic [ADDR_BITS-1:0] s;
        ue  = UW'(u);
        cap = UW'(1) << ADDR_BITS;
        if (ue == '0)
        begin
            ue = UW'(1);
        end
        if (ue > cap)
        begin
            ue = cap;
        end
        m = ADDR_BITS'(ue - UW'(1));
        s = m;
        for (int k = 1; k < ADDR_BITS; k = k * 2)
        begin
            s = s | (s >> k);
        end
        return {NW'(s) + NW'(1), m};
    endfunction

    localparam logic [NW+ADDR_BITS-1:0] GEOM_RESET = geom(UNIV_RESET);

    logic [NW-1:0]        base_reg;
    logic [ADDR_BITS-1:0] lim_reg;
    logic [RANGE_W-1:0]   lo_reg;
    logic [RANGE_W-1:0]   hi_reg;
    logic [LW-1:0]        l_reg;
    logic [LW-1:0]        r_reg;
    logic [SCW-1:0]       sc_reg;
    logic [ECW-1:0]       ec_reg;
    logic                 pend_valid_reg;
    logic [NW-1:0]        pend_node_reg;
    logic                 out_valid_reg;
    logic [NW-1:0]        out_node_reg;
    logic                 out_last_reg;

    logic [CW-1:0] lo_w;
    logic [CW-1:0] hi_w;
    logic [CW-1:0] lim_w;
    logic [CW-1:0] lo_cl;
    logic [CW-1:0] hi_cl;
    logic          l_odd;
    logic          r_even;
    logic [LW-1:0] l_inc;
    logic [LW-1:0] r_dec;
    logic          out_free;
    logic          emit_ok;
    logic          emit_fire;
    logic          emit_take;
    logic [NW-1:0] emit_node;
    logic          push;
    logic [NW-1:0] stack_rdata;
    logic [AW-1:0] pop_addr;

    // geometry follows every configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            {base_reg, lim_reg} <= GEOM_RESET;
        end
        else if (cfg_we)
        begin
            {base_reg, lim_reg} <= geom(cfg_value);
        end
    end

    assign lo_w  = CW'(lo_reg);
    assign hi_w  = CW'(hi_reg);
    assign lim_w = CW'(lim_reg);
    assign lo_cl = (lo_w > lim_w) ? lim_w : lo_w;
    assign hi_cl = (hi_w > lim_w) ? lim_w : hi_w;

    assign l_odd  = l_reg[0];
    assign r_even = !r_reg[0];
    assign l_inc  = l_odd  ? l_reg + LW'(1) : l_reg;
    assign r_dec  = r_even ? r_reg - LW'(1) : r_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign emit_fire = (cmd.step && l_odd) || cmd.pop_emit;
    assign emit_take = emit_fire && (ec_reg < ECW'(MAX_RESULTS));
    assign emit_node = cmd.pop_emit ? stack_rdata : l_reg[NW-1:0];
    assign push      = cmd.step && r_even && (sc_reg < SCW'(DEPTH));
    assign pop_addr  = AW'(sc_reg - SCW'(1));

    assign sts.l_le_r      = (l_reg <= r_reg);
    assign sts.step_ok     = !l_odd || emit_ok;
    assign sts.emit_ok     = emit_ok;
    assign sts.out_free    = out_free;
    assign sts.stack_empty = (sc_reg == '0);

    // query payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg <= (range_low > range_high) ? range_high : range_low;
            hi_reg <= (range_low > range_high) ? range_low : range_high;
        end
        if (cmd.setup)
        begin
            l_reg <= LW'(base_reg) + LW'(lo_cl);
            r_reg <= LW'(base_reg) + LW'(hi_cl);
        end
        else if (cmd.step)
        begin
            l_reg <= l_inc >> 1;
            r_reg <= r_dec >> 1;
        end
        if (emit_take)
        begin
            pend_node_reg <= emit_node;
        end
        if ((emit_take && pend_valid_reg) || cmd.finish)
        begin
            out_node_reg <= pend_node_reg;
            out_last_reg <= cmd.finish;
        end
    end

    // counters and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg         <= '0;
            ec_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sc_reg <= '0;
                ec_reg <= '0;
            end
            else
            begin
                if (push)
                begin
                    sc_reg <= sc_reg + SCW'(1);
                end
                else if (cmd.pop_rd)
                begin
                    sc_reg <= sc_reg - SCW'(1);
                end
                if (emit_take)
                begin
                    ec_reg <= ec_reg + ECW'(1);
                end
            end

            if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (emit_take)
            begin
                pend_valid_reg <= 1'b1;
            end

            if ((emit_take && pend_valid_reg) || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    strc_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (sc_reg[AW-1:0]),
        .wdata (r_reg[NW-1:0]),
        .re    (cmd.pop_rd),
        .raddr (pop_addr),
        .rdata (stack_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/segment_tree_range_cover_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_range_cover_top
// splits a closed range of leaf values into the canonical heap-numbered
// nodes of a complete binary tree, streamed out from left to right
// ----------------------------------------------------------------------------
// usage
//   cfg channel: universe size, written while the block is idle; cfg_ready is
//     always high. zero counts as one, values above 2**ADDR_BITS saturate
//   slave stream: one item per query, both bounds in tdata, in either order;
//     s_axis_tready is high only while no query is in progress
//   master stream: one item per cover node, tlast on the final node
//   sequence per query: the bounds are taken and ordered, then clamped into
//     leaf indices; the walk takes one tree level per step (at most ADDR_BITS+1)
//     and then leaves the walk; each node held on the right-side stack (at
//     most ADDR_BITS) takes a stack ram read, which is registered, and a hand-over;
//     finally the last node is released, and only then is a new query taken
//   stall: the walk and the stack unwind pause on a node to be emitted while
//     the held node and the output register are both full; nothing is dropped
//   reset: universe returns to 65536 (saturated), the stream stages empty
// ----------------------------------------------------------------------------
module segment_tree_range_cover_top #(
    parameter int ADDR_BITS = strc_pkg::ADDR_BITS_DEF,
    parameter int OUT_W     = ((ADDR_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write: universe_size
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [strc_pkg::UNIV_W-1:0]      cfg_data,
    // query input
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [strc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // range_low, range_high
    // cover output
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [OUT_W-1:0]                      m_axis_tdata,  // node_index, zero pad
    output logic                                  m_axis_tlast   // last_node
);

    import strc_pkg::*;

    strc_cmd_t          cmd;
    strc_sts_t          sts;
    logic [ADDR_BITS:0] node_index;

    // config is taken at any time, the contract keeps it to idle periods
    assign cfg_ready = 1'b1;

    strc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    strc_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_value  (cfg_data),
        .range_low  (s_axis_tdata[RANGE_W-1:0]),
        .range_high (s_axis_tdata[IN_TDATA_W-1:RANGE_W]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_node   (node_index),
        .out_last   (m_axis_tlast)
    );

    // node index in the low bits, pad bits read as zero
    assign m_axis_tdata = OUT_W'(node_index);

endmodule
`default_nettype wire

// ===== hdl/strc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strc_checker
// port-level checks on the segment tree range cover block
// ----------------------------------------------------------------------------
module strc_checker #(
    parameter int OUT_W = 24
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output item changed");

    // a query blocks further queries at least for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted back to back");

    // heap numbering never yields node zero
    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != '0))
        else $error("node index zero on output");

    // while a cover is still incomplete no new query is taken
    a_no_query_mid_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready before last node of cover");

endmodule

bind segment_tree_range_cover_top strc_checker #(
    .OUT_W (OUT_W)
) u_strc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== test/segment_tree_range_cover_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_cover_top_tb
// self-checking bench for the range cover block: queries go in on the slave
// stream and every cover node that comes out is compared with a local model
// of the upward tree walk, across several universe sizes and random stalls
// ----------------------------------------------------------------------------
module segment_tree_range_cover_top_tb;

    import strc_pkg::*;

    localparam int ADDR_BITS   = ADDR_BITS_DEF;
    localparam int NODE_W      = ADDR_BITS + 1;
    localparam int OUT_W       = ((ADDR_BITS + 1 + 7) / 8) * 8;
    localparam int STACK_DEPTH = ADDR_BITS + 1;
    localparam int UNIV_CAP    = 1 << ADDR_BITS;
    localparam int NUM_PHASES  = 13;
    localparam int PHASE_ITEMS = 31;
    localparam int MAX_WAIT    = 17;
    // receiver hold-off long enough to back the walk up into the input
    localparam int HOLD_CYCLES = 300;
    // every query yields a node, so a short pause is enough before a write
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 3 * ADDR_BITS + 20;
    // cycles with no item moving on any channel before giving up
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } cover_node_t;

    // per query: a node typed into the directed rows, or none
    typedef struct packed {
        logic              fixed;
        logic [NODE_W-1:0] node;
    } known_cover_t;

    typedef enum logic {
        ROW_QUERY,
        ROW_UNIVERSE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int unsigned a;       // range_low, or the universe for a write
        int unsigned b;       // range_high
        bit          fixed;   // cover is one known node
        int unsigned node;
    } directed_row_t;

    localparam int NUM_ROWS = 28;

    // directed part: extremes, reversed bounds, clamping, tiny and oversize universes
    directed_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_QUERY,    0,      65535,  1'b1, 1},       // whole tree after reset
        '{ROW_QUERY,    65535,  0,      1'b1, 1},       // bounds reversed
        '{ROW_QUERY,    0,      0,      1'b1, 65536},   // leftmost leaf
        '{ROW_QUERY,    65535,  65535,  1'b1, 131071},  // rightmost leaf
        '{ROW_QUERY,    0,      1,      1'b1, 32768},   // pair merged, via stack
        '{ROW_QUERY,    1,      2,      1'b0, 0},
        '{ROW_QUERY,    1,      65534,  1'b0, 0},       // longest cover
        '{ROW_QUERY,    12345,  54321,  1'b0, 0},
        '{ROW_QUERY,    43690,  21845,  1'b0, 0},
        '{ROW_UNIVERSE, 100,    0,      1'b0, 0},
        '{ROW_QUERY,    200,    300,    1'b1, 227},     // both bounds clamped
        '{ROW_QUERY,    300,    5,      1'b0, 0},
        '{ROW_QUERY,    0,      99,     1'b0, 0},
        '{ROW_UNIVERSE, 1,      0,      1'b0, 0},
        '{ROW_QUERY,    65535,  65535,  1'b1, 1},       // single leaf universe
        '{ROW_QUERY,    0,      7,      1'b1, 1},
        '{ROW_UNIVERSE, 0,      0,      1'b0, 0},
        '{ROW_QUERY,    3,      9,      1'b1, 1},       // zero counts as one
        '{ROW_UNIVERSE, 131071, 0,      1'b0, 0},
        '{ROW_QUERY,    0,      65535,  1'b1, 1},       // saturated universe
        '{ROW_QUERY,    65535,  1,      1'b0, 0},
        '{ROW_UNIVERSE, 65537,  0,      1'b0, 0},
        '{ROW_QUERY,    4660,   65535,  1'b0, 0},
        '{ROW_UNIVERSE, 2,      0,      1'b0, 0},
        '{ROW_QUERY,    0,      1,      1'b1, 1},
        '{ROW_QUERY,    1,      1,      1'b1, 3},
        '{ROW_QUERY,    65535,  0,      1'b1, 1},
        '{ROW_UNIVERSE, 65536,  0,      1'b0, 0}
    };

    int unsigned phase_univ [NUM_PHASES] = '{
        65536, 1, 0, 131071, 65535, 2, 3, 100, 32769, 0, 17, 4095, 65536
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [UNIV_W-1:0]     cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // range_low, range_high
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // node_index, zero pad
    logic                  m_axis_tlast;        // last_node

    // local copy of the universe register, follows every accepted write
    logic [UNIV_W-1:0]     universe_cfg = UNIV_RESET;
    cover_node_t           cover_q [$];         // nodes still owed by the block
    known_cover_t          known_q [$];         // one entry per query on offer
    int                    mismatches = 0;
    int                    quiet_cycles = 0;

    // knobs shared between the sender and the receiver
    bit                    tx_burst = 1'b0;
    bit                    rx_burst = 1'b0;
    bit                    hold_req = 1'b0;

    segment_tree_range_cover_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // cover prediction
    // ------------------------------------------------------------------------

    function automatic void owe_node(input int unsigned node, inout int count);
        cover_node_t c;
        if (count < MAX_RESULTS)
        begin
            c.node = node[NODE_W-1:0];
            c.last = 1'b0;
            cover_q = {cover_q, c};
            count++;
        end
    endfunction

    // walks both leaf indices up the tree; left nodes leave at once, right
    // nodes wait on a stack so the cover comes out left to right
    function automatic void predict_cover(input logic [RANGE_W-1:0] bound_a,
                                          input logic [RANGE_W-1:0] bound_b);
        int unsigned univ;
        int unsigned base;
        int unsigned lo;
        int unsigned hi;
        int unsigned l;
        int unsigned r;
        int unsigned right_nodes [$];
        int          count;
        univ  = 32'(universe_cfg);
        base  = 1;
        lo    = 32'(bound_a);
        hi    = 32'(bound_b);
        count = 0;
        if (univ == 0)
            univ = 1;
        if (univ > UNIV_CAP)
            univ = UNIV_CAP;
        while (base < univ)
            base = base << 1;
        if (lo > hi)
        begin
            lo = 32'(bound_b);
            hi = 32'(bound_a);
        end
        if (hi > univ - 1)
            hi = univ - 1;
        if (lo > univ - 1)
            lo = univ - 1;
        l = base + lo;
        r = base + hi;
        while (l <= r)
        begin
            if (l % 2 == 1)
            begin
                owe_node(l, count);
                l++;
            end
            if (r % 2 == 0)
            begin
                if (right_nodes.size() < STACK_DEPTH)
                    right_nodes = {right_nodes, r};
                r--;
            end
            l = l >> 1;
            r = r >> 1;
        end
        while (right_nodes.size() > 0)
            owe_node(right_nodes.pop_back(), count);
        if (count > 0)
            cover_q[cover_q.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // monitor: all channels sampled at the rising edge, before the block's
    // own updates of that edge land
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cover_node_t  want;
        known_cover_t known;
        cover_node_t  c;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                universe_cfg <= cfg_data;

            // a query's nodes can't come out on the edge that accepts it,
            // so checking and predicting in either order is safe
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cover_q.size() == 0)
                    report_mismatch("unexpected node", 32'(m_axis_tdata), 32'd0);
                else
                begin
                    want = cover_q.pop_front();
                    if (m_axis_tdata !== OUT_W'(want.node))
                        report_mismatch("node_index", 32'(m_axis_tdata),
                                        32'(want.node));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_node", 32'(m_axis_tlast),
                                        32'(want.last));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                known = known_q.pop_front();
                if (known.fixed)
                begin
                    c.node = known.node;
                    c.last = 1'b1;
                    cover_q = {cover_q, c};
                end
                else
                    predict_cover(s_axis_tdata[RANGE_W-1:0],
                                  s_axis_tdata[2*RANGE_W-1:RANGE_W]);
            end
        end

        // watchdog: nothing moving on any channel for too long
        if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // receiver: random hold-off before each node, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // returns on the edge that accepts the query, with tvalid still high
    task automatic send_query(input int unsigned lo, input int unsigned hi,
                              input bit fixed, input int unsigned node);
        known_cover_t known;
        int           gap;
        known.fixed = fixed;
        known.node  = node[NODE_W-1:0];
        known_q = {known_q, known};
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi[RANGE_W-1:0], lo[RANGE_W-1:0]};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // stop offering, let every owed node drain, then write the register
    task automatic write_universe(input int unsigned value);
        s_axis_tvalid <= 1'b0;
        while (cover_q.size() != 0 || known_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[UNIV_W-1:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned univ;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int          mode;
        int          pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run with no idling on the input side
        tx_burst = 1'b1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_UNIVERSE)
                write_universe(directed_rows[i].a);
            else
                send_query(directed_rows[i].a, directed_rows[i].b,
                           directed_rows[i].fixed, directed_rows[i].node);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            univ = (p == 9) ? $urandom_range(4, 131071) : phase_univ[p];
            write_universe(univ);
            // effective universe, as the block sees it
            span = (univ == 0) ? 1 : ((univ > UNIV_CAP) ? UNIV_CAP : univ);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            // long receiver hold while queries keep coming in
            if (p == 0 || p == 4)
            begin
                tx_burst = 1'b1;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                mode = $urandom_range(0, 3);
                unique case (mode)
                    0:
                    begin
                        lo = $urandom_range(0, 65535);
                        hi = $urandom_range(0, 65535);
                    end
                    1:
                    begin
                        lo = $urandom_range(0, span - 1);
                        hi = $urandom_range(0, span - 1);
                    end
                    2:
                    begin
                        // bounds at the edges of the universe and the field
                        pick = $urandom_range(0, 4);
                        lo   = (pick == 0) ? 0 : (pick == 1) ? span - 1 :
                               (pick == 2) ? span & 16'hFFFF : (pick == 3) ? 65535 :
                               $urandom_range(0, 3);
                        hi   = $urandom_range(0, 65535);
                        if ($urandom_range(0, 1) == 1)
                            hi = span - 1;
                    end
                    default:
                    begin
                        // narrow ranges, cover of a few nodes
                        lo = $urandom_range(0, span - 1);
                        hi = (lo + $urandom_range(0, 15)) & 16'hFFFF;
                    end
                endcase
                if ($urandom_range(0, 1) == 1)
                    send_query(lo, hi, 1'b0, 0);
                else
                    send_query(hi, lo, 1'b0, 0);
            end
        end

        // end of stimulus: drain, then give the block time to misbehave
        s_axis_tvalid <= 1'b0;
        rx_burst = 1'b0;
        while (cover_q.size() != 0 || known_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && cover_q.size() == 0 && known_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
